### src/circular_byte_fifo_macros.svh
// assertion macros used by the circular byte fifo datapath (cbf_dp)
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef CIRCULAR_BYTE_FIFO_MACROS_SVH
`define CIRCULAR_BYTE_FIFO_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CBF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("circular byte fifo assertion failed");

// next-cycle implication, disabled while in reset
`define CBF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("circular byte fifo assertion failed");

`endif

### src/cbf_pkg.sv
// package for the circular byte fifo: sizes, request codes, fsm states,
// controller command struct; no dependencies
package cbf_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned LEN_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned CFG_W  = 11;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 3'd0,
    REQ_GET   = 3'd1,
    REQ_PEEK  = 3'd2,
    REQ_DROP  = 3'd3,
    REQ_CLEAR = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic resp;
  } cmd_t;

endpackage

### src/cbf_ram.sv
// generic single write port ram with registered read
// no dependencies
module cbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/cbf_ctrl.sv
// controller fsm for the circular byte fifo: accept, execute, respond
// depends on cbf_pkg
module cbf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output cbf_pkg::cmd_t cmd_o
);

  cbf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      cbf_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = cbf_pkg::ST_EXEC;
        end
      end
      cbf_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = cbf_pkg::ST_RESP;
      end
      cbf_pkg::ST_RESP: begin
        cmd_o.resp = 1'b1;
        state_d    = cbf_pkg::ST_IDLE;
      end
      default: begin
        state_d = cbf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### src/cbf_dp.sv
// datapath for the circular byte fifo: indices, length, byte ram, result regs
// depends on cbf_pkg, cbf_ram and circular_byte_fifo_macros.svh
`include "circular_byte_fifo_macros.svh"

module cbf_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cbf_pkg::cmd_t               cmd_i,
  input  logic                        cfg_we_i,
  input  logic [cbf_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic [cbf_pkg::REQ_W-1:0]   req_type_i,
  input  logic [cbf_pkg::DATA_W-1:0]  data_in_i,
  input  logic [cbf_pkg::CNT_W-1:0]   drop_count_i,
  output logic                        done_o,
  output logic                        ok_o,
  output logic [cbf_pkg::DATA_W-1:0]  data_out_o,
  output logic [cbf_pkg::CNT_W-1:0]   dropped_o,
  output logic [cbf_pkg::CNT_W-1:0]   used_count_o,
  output logic [cbf_pkg::CNT_W-1:0]   free_count_o
);

  localparam int unsigned IDX_W = cbf_pkg::IDX_W;
  localparam int unsigned LEN_W = cbf_pkg::LEN_W;

  logic [LEN_W-1:0]           len_q;
  logic [IDX_W-1:0]           rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]           wr_idx_q, wr_idx_d;
  cbf_pkg::req_e              req_q;
  logic [cbf_pkg::DATA_W-1:0] din_q;
  logic [cbf_pkg::CNT_W-1:0]  cnt_q;
  logic                       ok_q, ok_d;
  logic                       rd_hit_q, rd_hit_d;
  logic [cbf_pkg::CNT_W-1:0]  dropped_q, dropped_d;
  logic [cbf_pkg::DATA_W-1:0] data_out_q;
  logic [cbf_pkg::CNT_W-1:0]  used_q, free_q;
  logic                       done_q;

  logic [LEN_W-1:0]           len_sat;
  logic [LEN_W-1:0]           used_now;
  logic [LEN_W-1:0]           cap;
  logic [LEN_W-1:0]           drop_amt;
  logic [LEN_W-1:0]           rd_inc, wr_inc, rd_adv;
  logic                       ram_we, ram_re;
  logic [cbf_pkg::DATA_W-1:0] ram_rdata;

  // saturate the written length to 2..DEPTH
  always_comb begin
    len_sat = cfg_wdata_i;
    if (cfg_wdata_i < LEN_W'(2)) begin
      len_sat = LEN_W'(2);
    end else if (cfg_wdata_i > LEN_W'(cbf_pkg::DEPTH)) begin
      len_sat = LEN_W'(cbf_pkg::DEPTH);
    end
  end

  // occupancy from the two indices
  always_comb begin
    if (wr_idx_q >= rd_idx_q) begin
      used_now = LEN_W'(wr_idx_q) - LEN_W'(rd_idx_q);
    end else begin
      used_now = len_q - LEN_W'(rd_idx_q) + LEN_W'(wr_idx_q);
    end
  end

  assign cap      = len_q - LEN_W'(1);
  assign drop_amt = (used_now < LEN_W'(cnt_q)) ? used_now : LEN_W'(cnt_q);
  assign rd_inc   = LEN_W'(rd_idx_q) + LEN_W'(1);
  assign wr_inc   = LEN_W'(wr_idx_q) + LEN_W'(1);
  assign rd_adv   = LEN_W'(rd_idx_q) + drop_amt;

  always_comb begin
    rd_idx_d  = rd_idx_q;
    wr_idx_d  = wr_idx_q;
    ok_d      = 1'b0;
    rd_hit_d  = 1'b0;
    dropped_d = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    unique case (req_q)
      cbf_pkg::REQ_PUT: begin
        if (used_now < cap) begin
          ram_we   = cmd_i.exec;
          ok_d     = 1'b1;
          wr_idx_d = (wr_inc >= len_q) ? '0 : wr_inc[IDX_W-1:0];
        end
      end
      cbf_pkg::REQ_GET, cbf_pkg::REQ_PEEK: begin
        ram_re = cmd_i.exec;
        if (used_now != '0) begin
          ok_d     = 1'b1;
          rd_hit_d = 1'b1;
          if (req_q == cbf_pkg::REQ_GET) begin
            rd_idx_d = (rd_inc >= len_q) ? '0 : rd_inc[IDX_W-1:0];
          end
        end
      end
      cbf_pkg::REQ_DROP: begin
        ok_d      = 1'b1;
        dropped_d = drop_amt[cbf_pkg::CNT_W-1:0];
        if (rd_adv >= len_q) begin
          rd_idx_d = IDX_W'(rd_adv - len_q);
        end else begin
          rd_idx_d = rd_adv[IDX_W-1:0];
        end
      end
      cbf_pkg::REQ_CLEAR: begin
        ok_d     = 1'b1;
        rd_idx_d = wr_idx_q;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // control state: length, indices and the done strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LEN_W'(cbf_pkg::DEPTH);
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.resp;
      if (cfg_we_i) begin
        len_q    <= len_sat;
        rd_idx_q <= '0;
        wr_idx_q <= '0;
      end else if (cmd_i.exec) begin
        rd_idx_q <= rd_idx_d;
        wr_idx_q <= wr_idx_d;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= cbf_pkg::req_e'(req_type_i);
      din_q <= data_in_i;
      cnt_q <= drop_count_i;
    end
    if (cmd_i.exec) begin
      ok_q      <= ok_d;
      rd_hit_q  <= rd_hit_d;
      dropped_q <= dropped_d;
    end
    if (cmd_i.resp) begin
      data_out_q <= rd_hit_q ? ram_rdata : '0;
      used_q     <= used_now[cbf_pkg::CNT_W-1:0];
      free_q     <= cbf_pkg::CNT_W'(cap - used_now);
    end
  end

  cbf_ram #(
    .WIDTH(cbf_pkg::DATA_W),
    .DEPTH(cbf_pkg::DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_idx_q),
    .wdata_i(din_q),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  assign done_o       = done_q;
  assign ok_o         = ok_q;
  assign data_out_o   = data_out_q;
  assign dropped_o    = dropped_q;
  assign used_count_o = used_q;
  assign free_count_o = free_q;

  `CBF_ASSERT_SAME(a_rd_idx_in_ring, 1'b1, LEN_W'(rd_idx_q) < len_q)
  `CBF_ASSERT_SAME(a_wr_idx_in_ring, 1'b1, LEN_W'(wr_idx_q) < len_q)
  `CBF_ASSERT_SAME(a_counts_sum, done_q, (LEN_W'(used_q) + LEN_W'(free_q)) == (len_q - LEN_W'(1)))
  `CBF_ASSERT_NEXT(a_resp_strobes, cmd_i.resp, done_q)

endmodule

### src/circular_byte_fifo.sv
// top level of the circular byte fifo: controller plus datapath
// depends on cbf_pkg, cbf_ctrl, cbf_dp (and cbf_ram below it)
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  -------------------------------------
// request   in         start_i && !busy_o        req_type_i, data_in_i, drop_count_i
// result    out        done_o (one cycle)        ok_o, data_out_o, dropped_o,
//                                                used_count_o, free_count_o
// config    in         cfg_we_i                  cfg_wdata_i (ring length)
//
// each word goes through accept, execute (ram access and index update) and
// respond (registered ram read data and counts), in that order, under the fsm
// done_o pulses for one cycle; a new word can be taken in that same cycle
// reset is asynchronous: indices to zero, ring length to 1024; ram content
// stays undefined and its data is never returned before a put wrote it, no clearing pass
// the receiver cannot stall, so done_o is never held
// a config write empties the buffer; the user must issue it only while idle, the block does not enforce it
module circular_byte_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request word
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [cbf_pkg::REQ_W-1:0]   req_type_i,
  input  logic [cbf_pkg::DATA_W-1:0]  data_in_i,
  input  logic [cbf_pkg::CNT_W-1:0]   drop_count_i,
  // ring length register
  input  logic                        cfg_we_i,
  input  logic [cbf_pkg::CFG_W-1:0]   cfg_wdata_i,
  // result word
  output logic                        done_o,
  output logic                        ok_o,
  output logic [cbf_pkg::DATA_W-1:0]  data_out_o,
  output logic [cbf_pkg::CNT_W-1:0]   dropped_o,
  output logic [cbf_pkg::CNT_W-1:0]   used_count_o,
  output logic [cbf_pkg::CNT_W-1:0]   free_count_o
);

  // command bundle from the fsm to the datapath
  cbf_pkg::cmd_t cmd;

  // fsm: idle -> exec -> resp -> idle
  cbf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  // indices, length, byte ram and result registers
  cbf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_type_i  (req_type_i),
    .data_in_i   (data_in_i),
    .drop_count_i(drop_count_i),
    .done_o      (done_o),
    .ok_o        (ok_o),
    .data_out_o  (data_out_o),
    .dropped_o   (dropped_o),
    .used_count_o(used_count_o),
    .free_count_o(free_count_o)
  );

endmodule

### dv/tb_circular_byte_fifo.sv
// self-checking testbench for circular_byte_fifo: directed and random request words
// checked against a behavioral ring model; depends on cbf_pkg and the rtl top only
`timescale 1ns / 1ps

module tb_circular_byte_fifo;

  localparam int unsigned DEPTH  = cbf_pkg::DEPTH;
  localparam int unsigned IDX_W  = cbf_pkg::IDX_W;
  localparam int unsigned DATA_W = cbf_pkg::DATA_W;
  localparam int unsigned CNT_W  = cbf_pkg::CNT_W;
  localparam int unsigned REQ_W  = cbf_pkg::REQ_W;
  localparam int unsigned CFG_W  = cbf_pkg::CFG_W;

  // request codes the block treats as no operation
  localparam logic [REQ_W-1:0] REQ_RSVD_5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;

  // ring length after reset and the length used for the fill test
  localparam logic [CFG_W-1:0] RESET_LEN = 11'd1024;
  localparam logic [CFG_W-1:0] FILL_LEN  = 11'd512;

  // accept, execute, respond, plus margin
  localparam int unsigned SETTLE_CYCLES  = 6;
  // longest quiet stretch: an idle gap at the largest gap_limit, a word in flight, a length write
  localparam int unsigned WATCHDOG_LIMIT = 400;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  dropped;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  free;
  } fifo_result_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start_i      = 1'b0;
  logic              busy_o;
  logic [REQ_W-1:0]  req_type_i   = '0;
  logic [DATA_W-1:0] data_in_i    = '0;
  logic [CNT_W-1:0]  drop_count_i = '0;
  logic              cfg_we_i     = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata_i  = '0;
  logic              done_o;
  logic              ok_o;
  logic [DATA_W-1:0] data_out_o;
  logic [CNT_W-1:0]  dropped_o;
  logic [CNT_W-1:0]  used_count_o;
  logic [CNT_W-1:0]  free_count_o;

  // ring model state
  logic [DATA_W-1:0] ring_bytes [0:DEPTH-1];
  int unsigned       ring_rd;
  int unsigned       ring_wr;
  logic [CFG_W-1:0]  ring_len;

  fifo_result_t      pending_results [$];
  int unsigned       gap_limit;
  int unsigned       fail_count;
  int unsigned       quiet_cycles;

  circular_byte_fifo u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .req_type_i   (req_type_i),
    .data_in_i    (data_in_i),
    .drop_count_i (drop_count_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .ok_o         (ok_o),
    .data_out_o   (data_out_o),
    .dropped_o    (dropped_o),
    .used_count_o (used_count_o),
    .free_count_o (free_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // length register saturated into 2..DEPTH
  function automatic int unsigned ring_slots();
    int unsigned slots;
    slots = 32'(ring_len);
    if (slots < 2) slots = 2;
    if (slots > DEPTH) slots = DEPTH;
    return slots;
  endfunction

  function automatic int unsigned bytes_held(int unsigned slots);
    if (ring_wr >= ring_rd) return ring_wr - ring_rd;
    return (slots - ring_rd) + ring_wr;
  endfunction

  // applies one request to the ring model and returns the result word it yields
  function automatic fifo_result_t apply_request(logic [REQ_W-1:0] kind,
                                                 logic [DATA_W-1:0] din,
                                                 logic [CNT_W-1:0] cnt);
    int unsigned  slots;
    int unsigned  held;
    int unsigned  n;
    fifo_result_t r;
    slots = ring_slots();
    held  = bytes_held(slots);
    r     = '0;
    case (kind)
      cbf_pkg::REQ_PUT: begin
        if (held < slots - 1) begin
          ring_bytes[ring_wr[IDX_W-1:0]] = din;
          ring_wr++;
          if (ring_wr >= slots) ring_wr = 0;
          r.ok = 1'b1;
        end
      end
      cbf_pkg::REQ_GET, cbf_pkg::REQ_PEEK: begin
        if (held >= 1) begin
          r.data = ring_bytes[ring_rd[IDX_W-1:0]];
          r.ok   = 1'b1;
          if (kind == cbf_pkg::REQ_GET) begin
            ring_rd++;
            if (ring_rd >= slots) ring_rd = 0;
          end
        end
      end
      cbf_pkg::REQ_DROP: begin
        n = (held < 32'(cnt)) ? held : 32'(cnt);
        ring_rd += n;
        if (ring_rd >= slots) ring_rd -= slots;
        r.dropped = CNT_W'(n);
        r.ok      = 1'b1;
      end
      cbf_pkg::REQ_CLEAR: begin
        ring_rd = ring_wr;
        r.ok    = 1'b1;
      end
      default: ;
    endcase
    held   = bytes_held(slots);
    r.used = CNT_W'(held);
    r.free = CNT_W'(slots - 1 - held);
    return r;
  endfunction

  function automatic void check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // result words arrive in request order, one per accepted word
  always @(posedge clk_i) begin
    fifo_result_t exp_r;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, expected none actual ok=%0d data=%0d",
                 $time, ok_o, data_out_o);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("ok", 32'(exp_r.ok), 32'(ok_o));
        check_field("data_out", 32'(exp_r.data), 32'(data_out_o));
        check_field("dropped", 32'(exp_r.dropped), 32'(dropped_o));
        check_field("used_count", 32'(exp_r.used), 32'(used_count_o));
        check_field("free_count", 32'(exp_r.free), 32'(free_count_o));
      end
    end
  end

  // ends the run when neither side moves a word for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("circular_byte_fifo test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // start stays high across back-to-back words, so it is only lowered on a gap or by drain_results
  task automatic issue_word(input logic [REQ_W-1:0] kind, input logic [DATA_W-1:0] din,
                            input logic [CNT_W-1:0] cnt);
    int unsigned gap;
    gap = $urandom_range(0, gap_limit);
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i      <= 1'b1;
    req_type_i   <= kind;
    data_in_i    <= din;
    drop_count_i <= cnt;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_results.push_back(apply_request(kind, din, cnt));
  endtask

  // sender holds off until every result word is back and the block is quiet
  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // a length write empties the ring, so the model indices go back to zero
  task automatic write_ring_length(input logic [CFG_W-1:0] len);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ring_len = len;
    ring_rd  = 0;
    ring_wr  = 0;
  endtask

  function automatic logic [REQ_W-1:0] pick_request(int unsigned put_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < put_pct) return cbf_pkg::REQ_PUT;
    roll = $urandom_range(0, 99);
    if (roll < 55) return cbf_pkg::REQ_GET;
    if (roll < 72) return cbf_pkg::REQ_PEEK;
    if (roll < 88) return cbf_pkg::REQ_DROP;
    if (roll < 95) return cbf_pkg::REQ_CLEAR;
    if (roll < 97) return REQ_RSVD_5;
    if (roll < 99) return REQ_RSVD_6;
    return REQ_RSVD_7;
  endfunction

  // reset length, empty-ring cases, both data extremes, unused codes
  task automatic test_directed();
    gap_limit = 2;
    issue_word(cbf_pkg::REQ_GET, 8'h00, '0);
    issue_word(cbf_pkg::REQ_PEEK, 8'hFF, '0);
    issue_word(cbf_pkg::REQ_DROP, 8'h00, 10'd1023);
    issue_word(cbf_pkg::REQ_CLEAR, 8'h00, '0);
    issue_word(cbf_pkg::REQ_PUT, 8'h00, '0);
    issue_word(cbf_pkg::REQ_PUT, 8'hFF, 10'd1023);
    issue_word(cbf_pkg::REQ_PEEK, 8'h00, '0);
    issue_word(cbf_pkg::REQ_GET, 8'h00, '0);
    issue_word(REQ_RSVD_5, 8'hFF, 10'd1023);
    issue_word(REQ_RSVD_6, 8'hFF, 10'd1023);
    issue_word(REQ_RSVD_7, 8'hFF, 10'd1023);
    issue_word(cbf_pkg::REQ_DROP, 8'h00, 10'd1023);
    issue_word(cbf_pkg::REQ_PUT, 8'hA5, '0);
    issue_word(cbf_pkg::REQ_CLEAR, 8'h00, '0);
    issue_word(cbf_pkg::REQ_GET, 8'h00, '0);
  endtask

  // smallest ring, saturation below 2 and above DEPTH
  task automatic test_length_limits();
    gap_limit = 3;
    write_ring_length(11'd2);
    issue_word(cbf_pkg::REQ_PUT, 8'h11, '0);
    issue_word(cbf_pkg::REQ_PUT, 8'h22, '0);
    issue_word(cbf_pkg::REQ_DROP, 8'h00, 10'd5);
    issue_word(cbf_pkg::REQ_GET, 8'h00, '0);
    write_ring_length(11'd0);
    issue_word(cbf_pkg::REQ_PUT, 8'h33, '0);
    issue_word(cbf_pkg::REQ_PUT, 8'h44, '0);
    write_ring_length(11'd1);
    issue_word(cbf_pkg::REQ_PUT, 8'h55, '0);
    write_ring_length(11'd3);
    issue_word(cbf_pkg::REQ_PUT, 8'h66, '0);
    issue_word(cbf_pkg::REQ_PUT, 8'h77, '0);
    issue_word(cbf_pkg::REQ_PUT, 8'h88, '0);
    write_ring_length(11'h7FF);
    issue_word(cbf_pkg::REQ_PUT, 8'h99, '0);
    issue_word(cbf_pkg::REQ_PEEK, 8'h00, '0);
  endtask

  // full ring at a 512-slot length: 511 held, overflow, drop of everything
  task automatic test_deep_fill();
    gap_limit = 0;
    write_ring_length(FILL_LEN);
    repeat (FILL_LEN) issue_word(cbf_pkg::REQ_PUT, DATA_W'($urandom_range(0, 255)),
                                 CNT_W'($urandom_range(0, 1023)));
    issue_word(cbf_pkg::REQ_DROP, 8'h00, 10'd1023);
    issue_word(cbf_pkg::REQ_PEEK, 8'h00, '0);
  endtask

  // phases of random traffic, each with its own length, put share and idling
  task automatic test_random_traffic();
    logic [CFG_W-1:0] len;
    logic [CNT_W-1:0] cnt;
    int unsigned      put_pct;
    int unsigned      words;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0:       len = CFG_W'($urandom_range(2, 6));
        1:       len = CFG_W'($urandom_range(7, 24));
        2:       len = CFG_W'($urandom_range(25, 90));
        default: len = CFG_W'($urandom_range(0, 2047));
      endcase
      write_ring_length(len);
      // alternate filling and draining so full and empty both come up
      case (phase % 3)
        0:       put_pct = 70;
        1:       put_pct = 35;
        default: put_pct = 52;
      endcase
      gap_limit = ($urandom_range(0, 2) == 0) ? 0 : 14;
      words     = 36 + $urandom_range(0, 6);
      for (int i = 0; i < words; i++) begin
        if ($urandom_range(0, 3) == 0) cnt = CNT_W'($urandom_range(0, 1023));
        else cnt = CNT_W'($urandom_range(0, 6));
        issue_word(pick_request(put_pct), DATA_W'($urandom_range(0, 255)), cnt);
        // occasional full stop mid-phase, then a switch of idling style
        if ($urandom_range(0, 59) == 0) begin
          drain_results();
          gap_limit = (gap_limit == 0) ? 14 : 0;
        end
      end
    end
  endtask

  initial begin
    gap_limit  = 0;
    fail_count = 0;
    ring_len   = RESET_LEN;
    ring_rd    = 0;
    ring_wr    = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_length_limits();
    test_deep_fill();
    test_random_traffic();
    drain_results();
    if (fail_count == 0) begin
      $display("circular_byte_fifo test passed");
    end else begin
      $display("circular_byte_fifo test failed");
    end
    $finish;
  end

endmodule
